// ===== rtl/dhfk_pkg.sv =====
// Types, constants and the CORDIC angle table for the DH forward kinematics unit.
// Used by the controller, the datapath and the top level.
`default_nettype none
package dhfk_pkg;

  localparam logic signed [31:0] ROT_ONE     = 32'sd1073741824;
  localparam logic signed [31:0] CORDIC_INIT = 32'sd652032874;
  // fraction bits of lengths and positions; common to all of them, so no shift depends on it
  localparam int LENGTH_FRAC_BITS = 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CORDIC_INIT,
    ST_CORDIC,
    ST_DH,
    ST_MAC,
    ST_COMMIT,
    ST_OUT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic       capture;     // latch input item
    logic       load_row;    // write base row from latched item
    logic       clear_count; // clear joint count
    logic       cordic_init; // start both CORDICs
    logic       cordic_step; // one CORDIC iteration
    logic [4:0] step_idx;
    logic       dh_build;    // build DH products, one per cycle
    logic [2:0] dh_idx;
    logic       mac;         // one product into the accumulator
    logic [3:0] mac_term;    // which output entry (0..11)
    logic [1:0] mac_k;       // which of the three products
    logic       commit;      // write new transform, bump count
    logic       out_load;    // fill output register
  } dhfk_cmd_t;

  typedef struct packed {
    logic       op_joint;
    logic [1:0] row;
  } dhfk_status_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/dhfk_ctrl.sv =====
// Controller of the DH forward kinematics unit: sequences load, CORDIC,
// DH build and the shared multiply-accumulate. Depends on dhfk_pkg.
`default_nettype none
module dhfk_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire                    out_stall,
  input  dhfk_pkg::dhfk_status_t status,
  output dhfk_pkg::dhfk_cmd_t    cmd
);
  import dhfk_pkg::*;

  state_t state, state_next;
  logic [4:0] step, step_next;
  logic [3:0] term, term_next;
  logic [1:0] k, k_next;
  logic out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= '0;
      term <= '0;
      k <= '0;
    end else begin
      state <= state_next;
      step <= step_next;
      term <= term_next;
      k <= k_next;
    end
  end

  // output register: cleared when taken, set on out_load
  always_ff @(posedge clk) begin
    if (rst) out_full <= 1'b0;
    else if (cmd.out_load) out_full <= 1'b1;
    else if (!out_stall) out_full <= 1'b0;
  end
  assign out_valid = out_full;

  always_comb begin
    state_next = state;
    step_next = step;
    term_next = term;
    k_next = k;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_LOAD;
      ST_LOAD: begin
        if (status.op_joint) state_next = ST_CORDIC_INIT;
        else if (status.row == 2'd2) state_next = ST_OUT;
        else state_next = ST_IDLE;
      end
      ST_CORDIC_INIT: begin
        step_next = '0;
        state_next = ST_CORDIC;
      end
      ST_CORDIC: begin
        step_next = step + 5'd1;
        if (step == 5'(CORDIC_STEPS - 1)) begin
          step_next = '0;
          state_next = ST_DH;
        end
      end
      ST_DH: begin
        step_next = step + 5'd1;
        if (step == 5'd5) begin
          term_next = '0;
          k_next = '0;
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        k_next = k + 2'd1;
        if (k == 2'd2) begin
          k_next = '0;
          term_next = term + 4'd1;
          if (term == 4'd11) state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: state_next = ST_OUT;
      ST_OUT: if (!out_full || !out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    cmd.step_idx = step;
    cmd.dh_idx = step[2:0];
    cmd.mac_term = term;
    cmd.mac_k = k;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.capture = in_valid;
      end
      ST_LOAD: begin
        cmd.load_row = !status.op_joint && status.row != 2'd3;
        cmd.clear_count = !status.op_joint && status.row == 2'd2;
      end
      ST_CORDIC_INIT: cmd.cordic_init = 1'b1;
      ST_CORDIC: cmd.cordic_step = 1'b1;
      ST_DH: cmd.dh_build = 1'b1;
      ST_MAC: cmd.mac = 1'b1;
      ST_COMMIT: cmd.commit = 1'b1;
      ST_OUT: cmd.out_load = !out_full || !out_stall;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/dhfk_datapath.sv =====
// Datapath of the DH forward kinematics unit: two CORDICs, one shared
// 32x32 multiplier with rounding accumulator, chain transform. Depends on dhfk_pkg.
`default_nettype none
module dhfk_datapath #(
  parameter int MAX_JOINTS   = 16
) (
  input  wire                         clk,
  input  wire                         rst,
  input  dhfk_pkg::dhfk_cmd_t         cmd,
  output dhfk_pkg::dhfk_status_t      status,
  input  wire                         in_operation,
  input  wire [1:0]                   in_row_select,
  input  wire signed [31:0]           in_base_col0,
  input  wire signed [31:0]           in_base_col1,
  input  wire signed [31:0]           in_base_col2,
  input  wire signed [31:0]           in_base_pos,
  input  wire signed [15:0]           in_link_twist,
  input  wire signed [31:0]           in_link_length,
  input  wire signed [15:0]           in_joint_angle,
  input  wire signed [31:0]           in_link_offset,
  output logic [4:0]                  joint_index,
  output logic signed [31:0]          pos_x,
  output logic signed [31:0]          pos_y,
  output logic signed [31:0]          pos_z
);
  import dhfk_pkg::*;

  localparam int CW = $clog2(MAX_JOINTS + 1);

  logic op;
  logic [1:0] row;
  logic signed [31:0] c0, c1, c2, cp, len, off;
  logic signed [15:0] twist, theta;

  logic signed [31:0] rot [9];
  logic signed [31:0] pos [3];
  logic [CW-1:0] count;

  // CORDIC state for alpha (a) and theta (t)
  logic signed [31:0] xa, ya, za, xt, yt, zt;
  logic flip_a, flip_t;
  // DH matrix and translation
  logic signed [31:0] dh [9];
  logic signed [31:0] pd [3];
  // new transform
  logic signed [31:0] nrot [9];
  logic signed [31:0] npos [3];
  logic signed [34:0] hi;
  logic [31:0] lo;

  assign status.op_joint = op;
  assign status.row = row;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op <= in_operation; row <= in_row_select;
      c0 <= in_base_col0; c1 <= in_base_col1; c2 <= in_base_col2; cp <= in_base_pos;
      twist <= in_link_twist; len <= in_link_length;
      theta <= in_joint_angle; off <= in_link_offset;
    end
  end

  function automatic logic fl(input logic signed [15:0] a);
    return (a > 16'sd16384) || (a < -16'sd16384);
  endfunction

  // CORDIC iterations, both angles in parallel
  logic [4:0] si;
  logic [31:0] at;
  assign si = cmd.step_idx;
  assign at = atan_entry(si);
  always_ff @(posedge clk) begin
    if (cmd.cordic_init) begin
      xa <= CORDIC_INIT; ya <= '0; xt <= CORDIC_INIT; yt <= '0;
      za <= {twist, 16'h0} + (fl(twist) ? 32'h80000000 : 32'h0);
      zt <= {theta, 16'h0} + (fl(theta) ? 32'h80000000 : 32'h0);
      flip_a <= fl(twist); flip_t <= fl(theta);
    end else if (cmd.cordic_step) begin
      if (!za[31]) begin
        xa <= xa - (ya >>> si); ya <= ya + (xa >>> si); za <= za - at;
      end else begin
        xa <= xa + (ya >>> si); ya <= ya - (xa >>> si); za <= za + at;
      end
      if (!zt[31]) begin
        xt <= xt - (yt >>> si); yt <= yt + (xt >>> si); zt <= zt - at;
      end else begin
        xt <= xt + (yt >>> si); yt <= yt - (xt >>> si); zt <= zt + at;
      end
    end
  end

  logic signed [31:0] ca, sa, ct, st;
  assign ca = flip_a ? -xa : xa;
  assign sa = flip_a ? -ya : ya;
  assign ct = flip_t ? -xt : xt;
  assign st = flip_t ? -yt : yt;

  // shared multiplier
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic [3:0] t;
  logic [1:0] kk;
  assign t = cmd.mac_term;
  assign kk = cmd.mac_k;

  // term 0..8 is rotation entry row*3+col, 9..11 the position of row term-9
  logic [3:0] rbase, kbase, ia, ib;
  logic [1:0] col, prow;
  always_comb begin
    rbase = 4'd0; col = 2'd0; prow = 2'd0;
    case (t)
      4'd0:  begin rbase = 4'd0; col = 2'd0; end
      4'd1:  begin rbase = 4'd0; col = 2'd1; end
      4'd2:  begin rbase = 4'd0; col = 2'd2; end
      4'd3:  begin rbase = 4'd3; col = 2'd0; end
      4'd4:  begin rbase = 4'd3; col = 2'd1; end
      4'd5:  begin rbase = 4'd3; col = 2'd2; end
      4'd6:  begin rbase = 4'd6; col = 2'd0; end
      4'd7:  begin rbase = 4'd6; col = 2'd1; end
      4'd8:  begin rbase = 4'd6; col = 2'd2; end
      4'd9:  begin rbase = 4'd0; prow = 2'd0; end
      4'd10: begin rbase = 4'd3; prow = 2'd1; end
      4'd11: begin rbase = 4'd6; prow = 2'd2; end
      default: ;
    endcase
    case (kk)
      2'd0: kbase = 4'd0;
      2'd1: kbase = 4'd3;
      default: kbase = 4'd6;
    endcase
  end
  assign ia = rbase + {2'b00, kk};
  assign ib = kbase + {2'b00, col};

  always_comb begin
    ma = '0; mb = '0;
    if (cmd.dh_build) begin
      case (cmd.dh_idx)
        3'd0: begin ma = st; mb = ca; end
        3'd1: begin ma = st; mb = sa; end
        3'd2: begin ma = ct; mb = ca; end
        3'd3: begin ma = ct; mb = sa; end
        3'd4: begin ma = len; mb = ct; end
        default: begin ma = len; mb = st; end
      endcase
    end else begin
      ma = rot[ia];
      if (t < 4'd9) mb = dh[ib];
      else mb = pd[kk];
    end
  end
  assign prod = ma * mb;

  // rounding of one product
  logic signed [31:0] r1;
  assign r1 = sat32(66'(prod >>> 30) + 66'({1'b0, prod[29:0]} + 31'h20000000 >> 30));

  always_ff @(posedge clk) begin
    if (cmd.dh_build) begin
      case (cmd.dh_idx)
        3'd0: dh[1] <= -r1;
        3'd1: dh[2] <= r1;
        3'd2: dh[4] <= r1;
        3'd3: dh[5] <= -r1;
        3'd4: pd[0] <= r1;
        default: begin
          pd[1] <= r1; pd[2] <= off;
          dh[0] <= ct; dh[3] <= st; dh[6] <= '0; dh[7] <= sa; dh[8] <= ca;
        end
      endcase
    end
  end

  // exact accumulation, rounded once
  logic signed [34:0] hi_n;
  logic [31:0] lo_n;
  logic signed [65:0] total;
  assign hi_n = (kk == 2'd0 ? 35'sd0 : hi) + 35'(prod >>> 30);
  assign lo_n = (kk == 2'd0 ? 32'd0 : lo) + {2'b0, prod[29:0]};
  assign total = 66'(hi_n) + (t >= 4'd9 ? 66'(pos[prow]) : 66'sd0)
               + 66'((lo_n + 32'h20000000) >> 30);

  always_ff @(posedge clk) begin
    if (cmd.mac) begin
      hi <= hi_n; lo <= lo_n;
      if (kk == 2'd2) begin
        if (t < 4'd9) nrot[t] <= sat32(total);
        else npos[prow] <= sat32(total);
      end
    end
  end

  logic [3:0] lbase;
  always_comb begin
    case (row)
      2'd0: lbase = 4'd0;
      2'd1: lbase = 4'd3;
      default: lbase = 4'd6;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) rot[i] <= (i % 4 == 0) ? ROT_ONE : 32'sd0;
      for (int i = 0; i < 3; i++) pos[i] <= '0;
      count <= '0;
    end else begin
      if (cmd.load_row) begin
        rot[lbase] <= c0; rot[lbase + 4'd1] <= c1; rot[lbase + 4'd2] <= c2;
        pos[row] <= cp;
      end
      if (cmd.clear_count) count <= '0;
      if (cmd.commit) begin
        for (int i = 0; i < 9; i++) rot[i] <= nrot[i];
        for (int i = 0; i < 3; i++) pos[i] <= npos[i];
        if (count < CW'(MAX_JOINTS)) count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      joint_index <= 5'(count);
      pos_x <= pos[0]; pos_y <= pos[1]; pos_z <= pos[2];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/dh_forward_kinematics_unit.sv =====
// DH forward kinematics unit, top level. Depends on dhfk_pkg, dhfk_ctrl, dhfk_datapath.
// One item at a time. A joint origin follows the CORDIC iterations, 6 DH products,
// 36 shared-multiplier products and the commit of the new transform; the next item
// is taken once the origin is in the output register. A row 2 load gives an origin
// too; rows 0, 1 and ignored rows give none. A stalled origin holds the unit.
// Synchronous reset sets the chain to identity at the origin and the count to zero.
`default_nettype none
module dh_forward_kinematics_unit #(
  parameter int MAX_JOINTS       = 16,
  parameter int CORDIC_STEPS     = 16
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire               operation,
  input  wire [1:0]         row_select,
  input  wire signed [31:0] base_col0,
  input  wire signed [31:0] base_col1,
  input  wire signed [31:0] base_col2,
  input  wire signed [31:0] base_pos,
  input  wire signed [15:0] link_twist,
  input  wire signed [31:0] link_length,
  input  wire signed [15:0] joint_angle,
  input  wire signed [31:0] link_offset,
  output logic              out_valid,
  input  wire               out_stall,
  output logic [4:0]        joint_index,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z
);
  import dhfk_pkg::*;

  dhfk_cmd_t cmd;
  dhfk_status_t status;

  dhfk_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .status, .cmd
  );

  dhfk_datapath #(.MAX_JOINTS(MAX_JOINTS)) u_dp (
    .clk, .rst, .cmd, .status,
    .in_operation(operation), .in_row_select(row_select),
    .in_base_col0(base_col0), .in_base_col1(base_col1), .in_base_col2(base_col2),
    .in_base_pos(base_pos), .in_link_twist(link_twist), .in_link_length(link_length),
    .in_joint_angle(joint_angle), .in_link_offset(link_offset),
    .joint_index, .pos_x, .pos_y, .pos_z
  );
endmodule
`default_nettype wire

// ===== tb/dh_forward_kinematics_unit_test.sv =====
// Self-checking test of dh_forward_kinematics_unit: base loads and DH joint items
// against a fixed-point chain model kept here. Depends on the RTL only.
`timescale 1ns / 100ps
`default_nettype none
module dh_forward_kinematics_unit_test;

  localparam int MAX_JOINTS   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int JOINT_CYCLES = CORDIC_STEPS + 47;
  localparam bit OP_LOAD  = 1'b0;
  localparam bit OP_JOINT = 1'b1;
  localparam logic [1:0] ROW_LAST = 2'd2;
  localparam logic [1:0] ROW_NONE = 2'd3;
  localparam longint ONE_Q30 = 64'sd1073741824;

  typedef struct packed {
    logic [4:0]  idx;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } origin_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic operation = 1'b0;
  logic [1:0] row_select = '0;
  logic signed [31:0] base_col0 = '0, base_col1 = '0, base_col2 = '0, base_pos = '0;
  logic signed [15:0] link_twist = '0, joint_angle = '0;
  logic signed [31:0] link_length = '0, link_offset = '0;
  logic out_stall = 1'b0;
  wire in_stall, out_valid;
  wire [4:0] joint_index;
  wire signed [31:0] pos_x, pos_y, pos_z;

  dh_forward_kinematics_unit dut (
    .clk, .rst, .in_valid, .in_stall, .operation, .row_select,
    .base_col0, .base_col1, .base_col2, .base_pos, .link_twist, .link_length,
    .joint_angle, .link_offset, .out_valid, .out_stall, .joint_index,
    .pos_x, .pos_y, .pos_z
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  longint rot[9];
  longint org[3];
  int unsigned chain_joints;
  origin_t origins_due[$];
  int errors = 0;
  int joints_sent = 0, loads_sent = 0, origins_seen = 0;

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint atan_q31(int i);
    longint t[32] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722,
      20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
    return t[i];
  endfunction

  // exact total of up to three Q2.30 products, rounded once
  function automatic longint round3(longint p0, longint p1, longint p2, longint acc);
    longint hi, lo;
    hi = asr(p0, 30) + asr(p1, 30) + asr(p2, 30);
    lo = (p0 & (ONE_Q30 - 1)) + (p1 & (ONE_Q30 - 1)) + (p2 & (ONE_Q30 - 1));
    return sat(acc + hi + asr(lo + (ONE_Q30 >>> 1), 30));
  endfunction

  function automatic longint mulr(longint a, longint b);
    return round3(a * b, 0, 0, 0);
  endfunction

  task automatic cordic(input logic signed [15:0] ang, output longint c, output longint s);
    logic [31:0] zu;
    bit flip;
    longint x, y, z, dx, dy;
    zu = {ang, 16'h0};
    flip = (ang > 16384 || ang < -16384);
    if (flip) zu = zu + 32'h8000_0000;
    z = longint'($signed(zu));
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_q31(i);
      end else begin
        x += dx; y -= dy; z += atan_q31(i);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic reset_chain();
    for (int k = 0; k < 9; k++) rot[k] = (k % 4 == 0) ? ONE_Q30 : 0;
    org = '{0, 0, 0};
    chain_joints = 0;
  endtask

  task automatic predict_origin(input bit op, input logic [1:0] row,
      input logic signed [31:0] c0, c1, c2, p, input logic signed [15:0] tw,
      input logic signed [31:0] len, input logic signed [15:0] th,
      input logic signed [31:0] off);
    longint ca, sa, c, s, dh[9], pd[3], nr[9], np[3];
    origin_t o;
    if (op == OP_LOAD) begin
      if (row == ROW_NONE) return;
      rot[row*3] = c0; rot[row*3+1] = c1; rot[row*3+2] = c2;
      org[row] = p;
      if (row != ROW_LAST) return;
      chain_joints = 0;
    end else begin
      cordic(tw, ca, sa);
      cordic(th, c, s);
      dh = '{c, -mulr(s, ca), mulr(s, sa), s, mulr(c, ca), -mulr(c, sa), 0, sa, ca};
      pd = '{mulr(len, c), mulr(len, s), longint'(off)};
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++)
          nr[r*3+j] = round3(rot[r*3]*dh[j], rot[r*3+1]*dh[3+j], rot[r*3+2]*dh[6+j], 0);
        np[r] = round3(rot[r*3]*pd[0], rot[r*3+1]*pd[1], rot[r*3+2]*pd[2], org[r]);
      end
      rot = nr;
      org = np;
      if (chain_joints < MAX_JOINTS) chain_joints++;
    end
    o.idx = chain_joints[4:0];
    o.x = org[0][31:0]; o.y = org[1][31:0]; o.z = org[2][31:0];
    origins_due = {origins_due, o};
  endtask

  // valid stays high into the next item unless a gap is drawn
  task automatic send_item(input bit op, input logic [1:0] row,
      input logic signed [31:0] c0, c1, c2, p, input logic signed [15:0] tw,
      input logic signed [31:0] len, input logic signed [15:0] th,
      input logic signed [31:0] off, input bit idle);
    int gap;
    gap = idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op; row_select <= row;
    base_col0 <= c0; base_col1 <= c1; base_col2 <= c2; base_pos <= p;
    link_twist <= tw; link_length <= len; joint_angle <= th; link_offset <= off;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_origin(op, row, c0, c1, c2, p, tw, len, th, off);
    if (op == OP_JOINT) joints_sent++; else loads_sent++;
  endtask

  function automatic logic signed [31:0] rnd32();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed(32'($urandom_range(0, 65535))) - 32768;
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic logic signed [31:0] rnd_length();
    if ($urandom_range(0, 9) == 0) return rnd32();
    return $signed(32'($urandom_range(0, 20 << 16))) - (10 << 16);
  endfunction

  task automatic send_joint(input logic signed [15:0] tw, th,
      input logic signed [31:0] len, off, input bit idle);
    send_item(OP_JOINT, 2'($urandom_range(0, 3)), rnd32(), rnd32(), rnd32(), rnd32(),
      tw, len, th, off, idle);
  endtask

  task automatic send_row(input logic [1:0] row, input logic signed [31:0] c0, c1, c2, p,
      input bit idle);
    send_item(OP_LOAD, row, c0, c1, c2, p, $signed(16'($urandom())), rnd32(),
      $signed(16'($urandom())), rnd32(), idle);
  endtask

  task automatic load_identity(input logic signed [31:0] px, py, pz);
    send_row(2'd0, 32'(ONE_Q30), 32'sd0, 32'sd0, px, 1'b0);
    send_row(2'd1, 32'sd0, 32'(ONE_Q30), 32'sd0, py, 1'b0);
    send_row(ROW_LAST, 32'sd0, 32'sd0, 32'(ONE_Q30), pz, 1'b0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (origins_due.size() != 0) @(posedge clk);
  endtask

  // receiver: random stall per item, compare each origin with the oldest prediction
  int stall_left = 0;
  always @(posedge clk) begin
    origin_t e;
    if (!rst && out_valid && !out_stall) begin
      origins_seen++;
      if (origins_due.size() == 0) begin
        $error("origin with none expected: idx %0d", joint_index);
        errors++;
      end else begin
        e = origins_due.pop_front();
        if (joint_index !== e.idx) begin
          $error("joint_index expected %0d got %0d", e.idx, joint_index); errors++;
        end
        if (pos_x !== e.x) begin
          $error("pos_x expected %0d got %0d", $signed(e.x), pos_x); errors++;
        end
        if (pos_y !== e.y) begin
          $error("pos_y expected %0d got %0d", $signed(e.y), pos_y); errors++;
        end
        if (pos_z !== e.z) begin
          $error("pos_z expected %0d got %0d", $signed(e.z), pos_z); errors++;
        end
      end
      stall_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left > 0);
  end

  task automatic test_directed();
    logic signed [15:0] angs[8] = '{0, 16384, -16384, 16385, -16385, 32767, -32768, 8192};
    send_row(ROW_NONE, rnd32(), rnd32(), rnd32(), rnd32(), 1'b0);
    send_joint(16'sd0, 16'sd0, 1 << 16, 0, 1'b0);  // joint straight from reset state
    load_identity(32'sh7fffffff, 32'sh80000000, 0);
    foreach (angs[i]) send_joint(angs[i], angs[7 - i], 3 << 16, -(2 << 16), 1'b0);
    // overflow: long links drive the origin into saturation
    send_joint(16'sd0, 16'sd0, 32'sh7fffffff, 32'sh7fffffff, 1'b0);
    send_joint(16'sh8000, 16'sd0, 32'sh80000000, 32'sh80000000, 1'b0);
    // extreme rotation rows
    send_row(2'd0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0, 1'b0);
    send_row(2'd1, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0, 1'b0);
    send_row(ROW_LAST, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 0, 1'b0);
    send_joint(16'sd12345, -16'sd23456, 32'sh7fffffff, 32'sh80000000, 1'b0);
    drain();
  endtask

  task automatic test_joint_limit();
    load_identity(0, 0, 0);
    repeat (MAX_JOINTS + 4)
      send_joint($signed(16'($urandom())), $signed(16'($urandom())), rnd_length(),
        rnd_length(), 1'b1);
    drain();
  endtask

  task automatic test_random_chains();
    int sent;
    sent = 0;
    while (sent < 1500) begin
      if ($urandom_range(0, 4) == 0) begin
        // noise: stray rows or ignored selects
        send_row(2'($urandom_range(0, 3)), rnd32(), rnd32(), rnd32(), rnd32(), 1'b1);
        sent++;
      end else begin
        send_row(2'd0, rnd32(), rnd32(), rnd32(), rnd_length(), 1'b1);
        send_row(2'd1, rnd32(), rnd32(), rnd32(), rnd_length(), 1'b1);
        send_row(ROW_LAST, rnd32(), rnd32(), rnd32(), rnd_length(), 1'b1);
        sent += 3;
        repeat ($urandom_range(1, 10)) begin
          send_joint($signed(16'($urandom())), $signed(16'($urandom())), rnd_length(),
            rnd_length(), 1'b1);
          sent++;
        end
      end
    end
    drain();
  endtask

  initial begin
    reset_chain();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_joint_limit();
    test_random_chains();
    repeat (4 * JOINT_CYCLES) @(posedge clk);
    $display("Sent %0d joint and %0d base-row items, checked %0d origins.",
      joints_sent, loads_sent, origins_seen);
    if (errors == 0 && origins_due.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire
